[design/pmt_pkg.sv]
// Shared constants, types and helpers for the point matrix transform core.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
package pmt_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int NUM_REGS   = 8;
    localparam int CFG_W      = 64;
    localparam int IDX_W      = 4;
    localparam int SEL_W      = $clog2(NUM_REGS);
    localparam int COORD_W    = 32;
    localparam int MODE_W     = 2;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int MAG_W      = PROD_W;
    localparam int DIV_BITS   = MAG_W + FRAC_BITS;
    localparam int DIV_SPS    = 4;
    localparam int DIV_STAGES = (DIV_BITS + DIV_SPS - 1) / DIV_SPS;
    localparam int MAC_STAGES = 3;
    localparam int PIPE_N     = MAC_STAGES + DIV_STAGES;

    localparam logic [MODE_W-1:0] MODE_FULL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INV  = 2'd2;

    localparam logic [COORD_W-1:0] ONE_FX  = COORD_W'(64'd1 << FRAC_BITS);
    localparam logic [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] NEG_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef logic [NUM_REGS-1:0][CFG_W-1:0] t_cfg_bank;

    typedef struct packed {
        logic [MODE_W-1:0]             mode;
        logic                          w_zero;
        logic [2:0]                    num_zero;
        logic [2:0]                    res_neg;
        logic [2:0][COORD_W-1:0]       rot;
        logic                          rot_sat;
    } t_side;

    typedef struct packed {
        t_side                         side;
        logic [2:0][MAG_W-1:0]         num_mag;
        logic [MAG_W-1:0]              den_mag;
    } t_mac_res;

    // coefficient at row r, column c (both from 0)
    function automatic logic signed [COORD_W-1:0] coef_of(t_cfg_bank bank, int r, int c);
        logic [CFG_W-1:0] word;
        word = bank[SEL_W'((r << 1) | (c >> 1))];
        return word[(c & 1) * COORD_W +: COORD_W];
    endfunction

endpackage

[design/pmt_mac.sv]
// Multiply and accumulate front end: products, dot-product sums, magnitudes.
// Depends on pmt_pkg.
`timescale 1ns / 1ps
module pmt_mac import pmt_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic signed [COORD_W-1:0]  i_x,
    input  logic signed [COORD_W-1:0]  i_y,
    input  logic signed [COORD_W-1:0]  i_z,
    input  t_cfg_bank                  i_cfg,
    output t_mac_res                   o_res
);

    logic signed [COORD_W-1:0] pt [3];
    logic signed [COORD_W-1:0] a_op [4][3];
    logic signed [COORD_W-1:0] a_bias [4];

    logic signed [PROD_W-1:0]  r_prod [4][3];
    logic signed [COORD_W-1:0] r_bias [4];
    logic [MODE_W-1:0]         r_mode_a;

    logic signed [ACC_W-1:0]   n_acc [4];
    logic signed [ACC_W-1:0]   r_acc [4];
    logic [MODE_W-1:0]         r_mode_b;

    t_mac_res                  n_res;
    t_mac_res                  r_res;

    assign pt[0] = i_x;
    assign pt[1] = i_y;
    assign pt[2] = i_z;

    // select operands: transposed 3x3 for inverse rotation, bias row only in full mode
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 3; k++) begin
                if (j < 3 && i_mode == MODE_INV) begin
                    a_op[j][k] = coef_of(i_cfg, j, k);
                end else begin
                    a_op[j][k] = coef_of(i_cfg, k, j);
                end
            end
            a_bias[j] = (i_mode == MODE_FULL) ? coef_of(i_cfg, 3, j) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 4; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[j][k] <= pt[k] * a_op[j][k];
                end
                r_bias[j] <= a_bias[j];
            end
            r_mode_a <= i_mode;
        end
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n_acc[j] = (ACC_W'(r_bias[j]) <<< FRAC_BITS)
                     + ACC_W'(r_prod[j][0]) + ACC_W'(r_prod[j][1]) + ACC_W'(r_prod[j][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc    <= n_acc;
            r_mode_b <= r_mode_a;
        end
    end

    // magnitudes and signs for the divider, scaled and clamped rotation results
    always_comb begin
        logic                    neg_w;
        logic                    neg_j;
        logic signed [ACC_W-1:0] mag;
        logic signed [ACC_W-1:0] shr;
        logic [ACC_W-COORD_W:0]  hi;
        logic                    clip;
        neg_w = r_acc[3][ACC_W-1];
        mag   = neg_w ? -r_acc[3] : r_acc[3];
        n_res.den_mag     = mag[MAG_W-1:0];
        n_res.side.mode   = r_mode_b;
        n_res.side.w_zero = (r_acc[3] == '0);
        n_res.side.rot_sat = 1'b0;
        for (int j = 0; j < 3; j++) begin
            neg_j = r_acc[j][ACC_W-1];
            mag   = neg_j ? -r_acc[j] : r_acc[j];
            n_res.num_mag[j]       = mag[MAG_W-1:0];
            n_res.side.num_zero[j] = (r_acc[j] == '0);
            n_res.side.res_neg[j]  = neg_j ^ neg_w;
            shr  = r_acc[j] >>> FRAC_BITS;
            hi   = shr[ACC_W-1:COORD_W-1];
            clip = !((&hi) || !(|hi));
            if (clip) begin
                n_res.side.rot[j] = shr[ACC_W-1] ? NEG_MIN : POS_MAX;
            end else begin
                n_res.side.rot[j] = shr[COORD_W-1:0];
            end
            if (clip && (r_mode_b == MODE_ROT || r_mode_b == MODE_INV)) begin
                n_res.side.rot_sat = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

[design/pmt_div.sv]
// Pipelined restoring divider lane: (num * 2^FRAC_BITS) / den, several bits per stage.
// Depends on pmt_pkg.
`timescale 1ns / 1ps
module pmt_div import pmt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [MAG_W-1:0]    i_num,
    input  logic [MAG_W-1:0]    i_den,
    output logic [COORD_W-1:0]  o_quo,
    output logic                o_big
);

    logic [MAG_W-1:0]    r_rem [DIV_STAGES];
    logic [DIV_BITS-1:0] r_dvd [DIV_STAGES];
    logic [MAG_W-1:0]    r_den [DIV_STAGES];
    logic [COORD_W-1:0]  r_quo [DIV_STAGES];
    logic                r_big [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [MAG_W-1:0]    p_rem;
        logic [DIV_BITS-1:0] p_dvd;
        logic [MAG_W-1:0]    p_den;
        logic [COORD_W-1:0]  p_quo;
        logic                p_big;
        logic [MAG_W-1:0]    n_rem;
        logic [DIV_BITS-1:0] n_dvd;
        logic [MAG_W-1:0]    n_den;
        logic [COORD_W-1:0]  n_quo;
        logic                n_big;

        // first stage takes the operands, later stages the previous stage
        if (s == 0) begin : g_first
            assign p_rem = '0;
            assign p_dvd = {i_num, {FRAC_BITS{1'b0}}};
            assign p_den = i_den;
            assign p_quo = '0;
            assign p_big = 1'b0;
        end else begin : g_next
            assign p_rem = r_rem[s-1];
            assign p_dvd = r_dvd[s-1];
            assign p_den = r_den[s-1];
            assign p_quo = r_quo[s-1];
            assign p_big = r_big[s-1];
        end

        always_comb begin
            logic [MAG_W:0] trial;
            logic           qb;
            n_rem = p_rem;
            n_dvd = p_dvd;
            n_den = p_den;
            n_quo = p_quo;
            n_big = p_big;
            trial = '0;
            qb    = 1'b0;
            for (int k = 0; k < DIV_SPS; k++) begin
                if (s * DIV_SPS + k < DIV_BITS) begin
                    trial = {n_rem, n_dvd[DIV_BITS-1]};
                    n_dvd = n_dvd << 1;
                    qb    = (trial >= {1'b0, n_den});
                    if (qb) begin
                        trial = trial - {1'b0, n_den};
                    end
                    n_rem = trial[MAG_W-1:0];
                    // a bit leaving the top means the quotient exceeds 32 bits
                    n_big = n_big | n_quo[COORD_W-1];
                    n_quo = {n_quo[COORD_W-2:0], qb};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_dvd[s] <= n_dvd;
                r_den[s] <= n_den;
                r_quo[s] <= n_quo;
                r_big[s] <= n_big;
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];
    assign o_big = r_big[DIV_STAGES-1];

endmodule

[design/point_matrix_transform_core.sv]
// Top level of the point matrix transform core: configuration bank, pipeline
// control, divider lanes and the saturating output register. Uses pmt_pkg, pmt_mac, pmt_div.
`timescale 1ns / 1ps
// Usage:
//  - Input channel (i_valid / o_stall) carries one item: request type and a
//    Q16.16 point. Output channel (o_valid / i_stall) returns one item per
//    input: the transformed point and the w_was_zero and saturated flags.
//  - Mode 0 multiplies the point (w = 1) by the 4x4 matrix and divides x, y, z
//    by w; mode 1 rotates by the upper 3x3; mode 2 by its transpose; mode 3
//    returns zeros.
//  - Configuration: eight 64-bit registers written through i_cfg_we,
//    i_cfg_idx and i_cfg_data; an index of 8 or more is dropped. Write only
//    while the pipeline holds no item.
//  - Throughput: one item per cycle while the output is not stalled. Pipeline:
//    3 multiply/accumulate stages, DIV_STAGES divider stages (80 quotient
//    bits, 4 per stage, so 20) and the output register.
//  - The whole pipeline advances as one; it holds when a result waits at the
//    output and the receiver stalls, and o_stall follows from that. Bubbles
//    travel as cleared valid bits, so nothing is lost or repeated.
//  - Reset (synchronous, active low) clears all valid bits and loads the
//    identity matrix into the configuration bank.
module point_matrix_transform_core import pmt_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [MODE_W-1:0]          i_req_type,
    input  logic signed [COORD_W-1:0]  i_in_x,
    input  logic signed [COORD_W-1:0]  i_in_y,
    input  logic signed [COORD_W-1:0]  i_in_z,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [COORD_W-1:0]  o_out_x,
    output logic signed [COORD_W-1:0]  o_out_y,
    output logic signed [COORD_W-1:0]  o_out_z,
    output logic                       o_w_was_zero,
    output logic                       o_saturated,
    input  logic                       i_cfg_we,
    input  logic [IDX_W-1:0]           i_cfg_idx,
    input  logic [CFG_W-1:0]           i_cfg_data
);

    t_cfg_bank             r_cfg;
    logic [PIPE_N-1:0]     r_vld;
    logic                  r_o_valid;
    logic                  adv;

    t_mac_res              mac_res;
    t_side                 r_side [DIV_STAGES];
    logic [COORD_W-1:0]    quo [3];
    logic                  big [3];

    logic [2:0][COORD_W-1:0] n_out;
    logic                  n_wz;
    logic                  n_sat;
    logic [2:0][COORD_W-1:0] r_out;
    logic                  r_wz;
    logic                  r_sat;

    // advance everything unless a finished item is held by the receiver
    assign adv     = !r_o_valid || !i_stall;
    assign o_stall = !adv;

    // configuration bank, identity after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= '0;
            r_cfg[0] <= {{(CFG_W-COORD_W){1'b0}}, ONE_FX};
            r_cfg[2] <= {ONE_FX, {(CFG_W-COORD_W){1'b0}}};
            r_cfg[5] <= {{(CFG_W-COORD_W){1'b0}}, ONE_FX};
            r_cfg[7] <= {ONE_FX, {(CFG_W-COORD_W){1'b0}}};
        end else if (i_cfg_we && i_cfg_idx < IDX_W'(NUM_REGS)) begin
            r_cfg[i_cfg_idx[SEL_W-1:0]] <= i_cfg_data;
        end
    end

    // valid bits travel alongside the data stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_vld     <= {r_vld[PIPE_N-2:0], i_valid};
            r_o_valid <= r_vld[PIPE_N-1];
        end
    end

    pmt_mac u_mac (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_mode (i_req_type),
        .i_x    (i_in_x),
        .i_y    (i_in_y),
        .i_z    (i_in_z),
        .i_cfg  (r_cfg),
        .o_res  (mac_res)
    );

    for (genvar j = 0; j < 3; j++) begin : g_lane
        pmt_div u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num (mac_res.num_mag[j]),
            .i_den (mac_res.den_mag),
            .o_quo (quo[j]),
            .o_big (big[j])
        );
    end

    // carry flags and rotation results alongside the divider stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= mac_res.side;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // final selection: sign, zero-w and overflow saturation
    always_comb begin
        t_side sd;
        sd    = r_side[DIV_STAGES-1];
        n_sat = 1'b0;
        n_wz  = 1'b0;
        for (int j = 0; j < 3; j++) begin
            n_out[j] = '0;
        end
        unique case (sd.mode)
            MODE_FULL: begin
                n_wz = sd.w_zero;
                for (int j = 0; j < 3; j++) begin
                    if (sd.w_zero) begin
                        if (!sd.num_zero[j]) begin
                            n_out[j] = sd.res_neg[j] ? NEG_MIN : POS_MAX;
                            n_sat    = 1'b1;
                        end
                    end else if (sd.res_neg[j]) begin
                        if (big[j] || (quo[j][COORD_W-1] && |quo[j][COORD_W-2:0])) begin
                            n_out[j] = NEG_MIN;
                            n_sat    = 1'b1;
                        end else begin
                            n_out[j] = -quo[j];
                        end
                    end else begin
                        if (big[j] || quo[j][COORD_W-1]) begin
                            n_out[j] = POS_MAX;
                            n_sat    = 1'b1;
                        end else begin
                            n_out[j] = quo[j];
                        end
                    end
                end
            end
            MODE_ROT, MODE_INV: begin
                n_out = sd.rot;
                n_sat = sd.rot_sat;
            end
            default: begin
                n_sat = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
            r_wz  <= n_wz;
            r_sat <= n_sat;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_out_x      = r_out[0];
    assign o_out_y      = r_out[1];
    assign o_out_z      = r_out[2];
    assign o_w_was_zero = r_wz;
    assign o_saturated  = r_sat;

endmodule
